>>> hw/rtl/msld_pkg.sv
// Package for the magic-word sync, length-prefixed deframer.
// Holds the shared constants, the byte kind codes and the result record.
// No dependencies.
`timescale 1ns / 1ps

package msld_pkg;

    typedef logic [8:0] t_count;
    typedef logic [7:0] t_byte;

    localparam logic [31:0] SYNC_WORD_RESET = 32'hF6A8885A;
    localparam t_count      WINDOW_BYTES    = 9'd4;
    localparam t_count      HEADER_BYTES    = 9'd8;
    localparam t_count      TYPE_POS        = WINDOW_BYTES + 9'd1;
    localparam t_count      SIZE_POS        = WINDOW_BYTES + 9'd2;
    localparam t_count      MAX_PAYLOAD     = 9'd255;

    typedef enum logic [1:0] {
        KIND_SYNC    = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2
    } t_byte_kind;

    typedef struct packed {
        t_byte_kind byte_kind;
        t_byte      payload_byte;
        t_byte      payload_offset;
        t_byte      frame_type;
        t_byte      frame_size;
        logic       frame_end;
    } t_result;

endpackage

>>> hw/rtl/msld_frame_core.sv
// Frame tracking core: sync window, byte counter and held header fields.
// Produces the description of one byte and updates the state when enabled.
// Depends on msld_pkg.
`timescale 1ns / 1ps

module msld_frame_core
    import msld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_byte       i_rx_byte,
    input  logic [31:0] i_sync_word,
    output t_result     o_result
);

    logic [31:0] r_window;
    t_count      r_count;
    t_byte       r_type;
    t_byte       r_size;

    logic [31:0] n_window;
    t_count      n_count;
    t_byte       n_type;
    t_byte       n_size;
    t_count      count_inc;
    t_count      offset_full;

    assign count_inc   = r_count + 9'd1;
    assign offset_full = count_inc - HEADER_BYTES - 9'd1;

    always_comb begin
        n_window = r_window;
        n_count  = count_inc;
        n_type   = r_type;
        n_size   = r_size;
        o_result = '0;
        if (r_count < WINDOW_BYTES) begin
            n_window = {i_rx_byte, r_window[31:8]};
            if (count_inc == WINDOW_BYTES) begin
                if (n_window != i_sync_word) begin
                    n_count = WINDOW_BYTES - 9'd1;
                end else begin
                    n_type = '0;
                    n_size = '0;
                end
            end
            o_result.byte_kind = KIND_SYNC;
        end else begin
            if (count_inc <= HEADER_BYTES) begin
                o_result.byte_kind = KIND_HEADER;
                if (count_inc == TYPE_POS) begin
                    n_type = i_rx_byte;
                end else if (count_inc == SIZE_POS) begin
                    if ({1'b0, i_rx_byte} > MAX_PAYLOAD) begin
                        n_size = MAX_PAYLOAD[7:0];
                    end else begin
                        n_size = i_rx_byte;
                    end
                end
            end else begin
                o_result.byte_kind      = KIND_PAYLOAD;
                o_result.payload_byte   = i_rx_byte;
                o_result.payload_offset = offset_full[7:0];
            end
            if (count_inc >= HEADER_BYTES && count_inc == ({1'b0, n_size} + HEADER_BYTES)) begin
                o_result.frame_end = 1'b1;
                n_count            = '0;
            end
        end
        o_result.frame_type = n_type;
        o_result.frame_size = n_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_count  <= '0;
            r_type   <= '0;
            r_size   <= '0;
        end else if (i_en) begin
            r_window <= n_window;
            r_count  <= n_count;
            r_type   <= n_type;
            r_size   <= n_size;
        end
    end

endmodule

>>> hw/rtl/magic_sync_length_deframer.sv
// Magic-word sync, length-prefixed deframer: one received byte per input
// transaction, one result transaction per byte. The block accepts a byte in
// every cycle while o_in_stall is low. An accepted byte waits in the input
// register while the frame core compares the four-byte window and steps the
// byte counter; its description is then captured in the result register, or
// in the skid entry when the result register is still held by a stall.
// A two-entry result buffer lets input continue while a result waits, and
// input stalls only once that buffer and the input register are all full.
// The sync word register should be written only while no byte is in flight.
`timescale 1ns / 1ps

module magic_sync_length_deframer
    import msld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_sync_word,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_byte_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_payload_offset,
    output logic [7:0]  o_frame_type,
    output logic [7:0]  o_frame_size,
    output logic        o_frame_end
);

    logic [31:0] r_sync_word;
    logic        r_in_valid;
    t_byte       r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        in_accept;
    logic        go;
    logic        drain;
    t_result     core_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_valid & r_skid_valid;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign go          = r_in_valid & ~r_skid_valid;
    assign drain       = r_out_valid & ~i_out_stall;

    msld_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (go),
        .i_rx_byte   (r_in_byte),
        .i_sync_word (r_sync_word),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= SYNC_WORD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sync_word <= i_cfg_sync_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept | (r_in_valid & ~go);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (drain) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (go) begin
            if (!r_out_valid || drain) begin
                r_out       <= core_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= core_result;
                r_skid_valid <= 1'b1;
            end
        end else if (drain) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_kind      = r_out.byte_kind;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_offset = r_out.payload_offset;
    assign o_frame_type     = r_out.frame_type;
    assign o_frame_size     = r_out.frame_size;
    assign o_frame_end      = r_out.frame_end;

endmodule

>>> hw/rtl/msld_checker.sv
// Port-level assertions for the magic-word sync deframer.
// Bound to magic_sync_length_deframer; depends on msld_pkg.
`timescale 1ns / 1ps

module msld_checker
    import msld_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_byte_kind,
    input logic [7:0]  o_payload_byte,
    input logic [7:0]  o_payload_offset,
    input logic [7:0]  o_frame_size,
    input logic        o_frame_end
);

    a_end_not_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_byte_kind != KIND_SYNC)
        else $error("frame end reported on a sync window byte");

    a_nonpayload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_kind != KIND_PAYLOAD
        |-> o_payload_byte == 8'd0 && o_payload_offset == 8'd0)
        else $error("payload fields set on a byte that is not payload");

    a_offset_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_kind == KIND_PAYLOAD |-> o_payload_offset < o_frame_size)
        else $error("payload offset beyond the frame size");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_kind == KIND_SYNC || o_byte_kind == KIND_HEADER
                        || o_byte_kind == KIND_PAYLOAD)
        else $error("undefined byte kind");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_kind)
        && $stable(o_payload_byte) && $stable(o_frame_end))
        else $error("stalled result transaction changed");

endmodule

bind magic_sync_length_deframer msld_checker u_msld_checker (.*);

>>> test/testbench.sv
// Testbench for the magic-word sync, length-prefixed deframer: a directed stimulus
// table, then random frames; every result checked against its row or a predictor.
// Depends on msld_pkg and magic_sync_length_deframer.
`timescale 1ns / 1ps

module testbench;
    import msld_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_BYTES = 270;
    localparam int NUM_PHASES  = 6;
    localparam int PRINT_LIMIT = 30;

    typedef struct packed {
        t_byte   rx;
        logic    typed;
        t_result want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_sync_word;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_byte_kind;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_payload_offset;
    logic [7:0]  o_frame_type;
    logic [7:0]  o_frame_size;
    logic        o_frame_end;

    // Predictor state of the deframer.
    logic [31:0] sync_word_cfg;
    logic [31:0] window_bytes;
    t_count      frame_count;
    t_byte       held_type;
    t_byte       held_size;

    t_result     pending_results[$];
    t_row        stimulus_table[$];
    t_result     want;

    int error_count;
    int bytes_sent;
    int results_checked;
    int frames_closed;
    int payload_seen;
    int empty_frames;
    int sync_settings;
    int burst_left;
    int idle_cycles;
    int stall_left;
    int stall_mode;
    int stall_phase;

    magic_sync_length_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_sync_word  (i_cfg_sync_word),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_byte_kind      (o_byte_kind),
        .o_payload_byte   (o_payload_byte),
        .o_payload_offset (o_payload_offset),
        .o_frame_type     (o_frame_type),
        .o_frame_size     (o_frame_size),
        .o_frame_end      (o_frame_end)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_result make_result(input t_byte_kind kind, input t_byte pbyte,
                                            input t_byte poff, input t_byte ftype,
                                            input t_byte fsize, input logic fend);
        t_result r;
        r.byte_kind      = kind;
        r.payload_byte   = pbyte;
        r.payload_offset = poff;
        r.frame_type     = ftype;
        r.frame_size     = fsize;
        r.frame_end      = fend;
        return r;
    endfunction

    function automatic t_result deframe_byte(input t_byte b);
        t_result r;
        t_count  n;
        r = '0;
        r.byte_kind = KIND_SYNC;
        if (frame_count < WINDOW_BYTES) begin
            window_bytes = {b, window_bytes[31:8]};
            frame_count  = frame_count + 9'd1;
            if (frame_count == WINDOW_BYTES) begin
                if (window_bytes != sync_word_cfg) begin
                    frame_count = WINDOW_BYTES - 9'd1;
                end else begin
                    held_type = '0;
                    held_size = '0;
                end
            end
        end else begin
            frame_count = frame_count + 9'd1;
            n = frame_count;
            if (n <= HEADER_BYTES) begin
                r.byte_kind = KIND_HEADER;
                if (n == TYPE_POS) begin
                    held_type = b;
                end else if (n == SIZE_POS) begin
                    held_size = (t_count'(b) > MAX_PAYLOAD) ? t_byte'(MAX_PAYLOAD) : b;
                end
            end else begin
                r.byte_kind      = KIND_PAYLOAD;
                r.payload_byte   = b;
                r.payload_offset = t_byte'(n - HEADER_BYTES - 9'd1);
            end
            if (n >= HEADER_BYTES && n == t_count'(held_size) + HEADER_BYTES) begin
                r.frame_end = 1'b1;
                frame_count = '0;
            end
        end
        r.frame_type = held_type;
        r.frame_size = held_size;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (error_count < PRINT_LIMIT) begin
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                     got, exp_val);
        end
        error_count++;
    endtask

    task automatic send_byte(input t_byte b, input logic typed, input t_result typed_want);
        int      gap;
        int      pick;
        t_result predicted;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                gap = 0;
            end else if (pick < 9) begin
                gap = $urandom_range(1, 4);
            end else begin
                gap = $urandom_range(5, 30);
            end
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        bytes_sent++;
        predicted = deframe_byte(b);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    task automatic add_row(input t_byte rx, input logic typed, input t_result row_want);
        t_row row;
        row.rx    = rx;
        row.typed = typed;
        row.want  = row_want;
        stimulus_table.push_back(row);
    endtask

    task automatic write_sync_word(input logic [31:0] value);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_sync_word <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        sync_word_cfg = value;
        sync_settings++;
    endtask

    task automatic send_random_traffic(input int count);
        int     start;
        int     pick;
        int     k;
        int     len;
        int     size_pick;
        t_byte  fsize;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
                for (k = 0; k < len; k++) send_byte(t_byte'($urandom), 1'b0, '0);
                for (k = 0; k < 4; k++) send_byte(sync_word_cfg[8*k +: 8], 1'b0, '0);
                send_byte(t_byte'($urandom), 1'b0, '0);
                size_pick = $urandom_range(0, 59);
                if (size_pick == 0) begin
                    fsize = 8'hFF;
                end else if (size_pick < 4) begin
                    fsize = t_byte'($urandom_range(11, 254));
                end else begin
                    fsize = t_byte'($urandom_range(0, 10));
                end
                send_byte(fsize, 1'b0, '0);
                for (k = 0; k < 2 + int'(fsize); k++) send_byte(t_byte'($urandom), 1'b0, '0);
            end else if (pick == 7) begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++) send_byte(sync_word_cfg[8*k +: 8], 1'b0, '0);
                send_byte(t_byte'($urandom), 1'b0, '0);
            end else begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) send_byte(t_byte'($urandom), 1'b0, '0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 1);
            default: i_out_stall <= ((stall_phase % 8) < 5);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", o_byte_kind, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_byte_kind != want.byte_kind)
                    report_mismatch("byte_kind", o_byte_kind, want.byte_kind);
                if (o_payload_byte != want.payload_byte)
                    report_mismatch("payload_byte", o_payload_byte, want.payload_byte);
                if (o_payload_offset != want.payload_offset)
                    report_mismatch("payload_offset", o_payload_offset, want.payload_offset);
                if (o_frame_type != want.frame_type)
                    report_mismatch("frame_type", o_frame_type, want.frame_type);
                if (o_frame_size != want.frame_size)
                    report_mismatch("frame_size", o_frame_size, want.frame_size);
                if (o_frame_end != want.frame_end)
                    report_mismatch("frame_end", o_frame_end, want.frame_end);
                results_checked++;
                if (want.frame_end) frames_closed++;
                if (want.frame_end && want.byte_kind == KIND_HEADER) empty_frames++;
                if (want.byte_kind == KIND_PAYLOAD) payload_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles with no transaction", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int      phase;
        logic [31:0] next_word;
        t_result sync_zero;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_sync_word <= '0;
        i_in_valid      <= 1'b0;
        i_rx_byte       <= '0;
        sync_word_cfg   = SYNC_WORD_RESET;
        window_bytes    = '0;
        frame_count     = '0;
        held_type       = '0;
        held_size       = '0;
        sync_settings   = 1;

        // After reset the magic opens an empty frame of type 0xFF.
        sync_zero = make_result(KIND_SYNC, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        add_row(8'h5A, 1'b1, sync_zero);
        add_row(8'h88, 1'b1, sync_zero);
        add_row(8'hA8, 1'b1, sync_zero);
        add_row(8'hF6, 1'b1, sync_zero);
        add_row(8'hFF, 1'b1, make_result(KIND_HEADER, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
        add_row(8'h00, 1'b1, make_result(KIND_HEADER, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
        add_row(8'h00, 1'b1, make_result(KIND_HEADER, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
        add_row(8'hFF, 1'b1, make_result(KIND_HEADER, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1));
        // Hunting shows the last held header, then a two-byte frame of extreme payload.
        add_row(8'h00, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h5A, 1'b0, '0);
        add_row(8'h5A, 1'b0, '0);
        add_row(8'h88, 1'b0, '0);
        add_row(8'hA8, 1'b0, '0);
        add_row(8'hF6, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h02, 1'b0, '0);
        add_row(8'h55, 1'b0, '0);
        add_row(8'hAA, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stimulus_table[i])
            send_byte(stimulus_table[i].rx, stimulus_table[i].typed, stimulus_table[i].want);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: next_word = SYNC_WORD_RESET;
                1: next_word = 32'h0000_0000;
                2: next_word = 32'hFFFF_FFFF;
                3, 4: next_word = $urandom;
                default: next_word = SYNC_WORD_RESET;
            endcase
            if (phase != 0) write_sync_word(next_word);
            send_random_traffic(PHASE_BYTES);
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d bytes sent, %0d results checked: %0d frames closed (%0d empty),",
                 bytes_sent, results_checked, frames_closed, empty_frames);
        $display("%0d payload bytes, %0d sync word settings incl. all-zero and all-one; %0d mismatches",
                 payload_seen, sync_settings, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> magic_sync_length_deframer.f
hw/rtl/msld_pkg.sv
hw/rtl/msld_frame_core.sv
hw/rtl/magic_sync_length_deframer.sv
hw/rtl/msld_checker.sv
test/testbench.sv
